>>> src/segalloc_pkg.sv
// Shared types and codes for the segment allocator.
// Used by segalloc_cell and segment_allocator_fit_policy; depends on nothing.
`default_nettype none
package segalloc_pkg;

  localparam int ADDR_BITS = 16;
  localparam int LEN_W     = ADDR_BITS + 1;
  localparam int ID_W      = 31;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [0:0] REG_FIT_MODE   = 1'd0;
  localparam logic [0:0] REG_ARENA_SIZE = 1'd1;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NOFIT  = 3'd1;
  localparam logic [2:0] ST_NOID   = 3'd2;
  localparam logic [2:0] ST_NOINIT = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;
  localparam logic [2:0] ST_ZERO   = 3'd5;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_INIT  = 3'd1;
  localparam logic [2:0] CMD_EXACT = 3'd2;
  localparam logic [2:0] CMD_SPLIT = 3'd3;
  localparam logic [2:0] CMD_FREE  = 3'd4;
  localparam logic [2:0] CMD_MERGE = 3'd5;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0]     len;
    logic [ID_W-1:0]      owner;
    logic                 used;
  } entry_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic                 found;
    logic                 fresh;
    logic                 pfree;
    logic                 nfree;
    logic [LEN_W-1:0]     len;
    logic [ADDR_BITS-1:0] start;
  } tok_t;

  typedef struct packed {
    logic [2:0]       code;
    logic [LEN_W-1:0] size;
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] init_len;
  } cmd_t;

endpackage
`default_nettype wire

>>> src/segment_allocator_fit_policy.sv
// Segment allocator top level: control sequencer and the row of table cells.
// Depends on segalloc_pkg and segalloc_cell.
`default_nettype none
// Keeps an address-ordered table of up to MAX_SEGMENTS segments, one per cell
// of a cell row. Op 0 allocates by first, best or worst fit (fit_mode), op 1
// frees by owner id and merges free neighbours, op 2 sets up one free segment
// of arena_size units, capped at 65536. Allocate and free send a search token
// down the whole row, one cell per cycle, and a matched free then takes its two
// merge steps. One transaction is worked on at a time; a finished result waits
// in the output register. Configuration writes are taken at any cycle.
module segment_allocator_fit_policy #(
  parameter int MAX_SEGMENTS = 64
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [1:0]                    op,
  input  wire [16:0]                   request_size,
  input  wire [30:0]                   release_id,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [2:0]                   status,
  output logic [30:0]                  granted_id,
  output logic [15:0]                  granted_start,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [0:0]                    cfg_index,
  input  wire [16:0]                   cfg_data
);

  localparam int N  = MAX_SEGMENTS;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int LW = segalloc_pkg::LEN_W;
  localparam int AW = segalloc_pkg::ADDR_BITS;
  localparam int DW = segalloc_pkg::ID_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_INIT   = 3'd2;
  localparam logic [2:0] S_MERGE1 = 3'd3;
  localparam logic [2:0] S_MERGE2 = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  localparam logic [LW-1:0] ARENA_MAX = LW'(1) << AW;

  logic [2:0]    state;
  logic [1:0]    fit_mode;
  logic [16:0]   arena_size;
  logic [CW-1:0] count;
  logic [DW-1:0] next_id;
  logic [CW-1:0] scan_cnt;
  logic [1:0]    op_q;
  logic [LW-1:0] size_q;
  logic [DW-1:0] rid_q;
  logic [IW-1:0] k_q;
  logic          nfree_q;
  logic          pfree_q;
  logic [2:0]    res_status;
  logic [DW-1:0] res_id;
  logic [AW-1:0] res_start;

  segalloc_pkg::cmd_t   cmd;
  logic [IW-1:0]        cmd_k;
  segalloc_pkg::entry_t ents    [N];
  segalloc_pkg::entry_t lefts   [N];
  segalloc_pkg::entry_t rights  [N];
  segalloc_pkg::tok_t   toks    [N+1];
  logic [IW-1:0]        tok_idx [N+1];
  segalloc_pkg::entry_t edge_ent;

  logic          scan_done;
  logic          split;
  logic [DW-1:0] id_inc;

  assign edge_ent   = '{start: '0, len: '0, owner: '0, used: 1'b1};
  assign toks[0]    = '0;
  assign tok_idx[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_l0
      assign lefts[i] = edge_ent;
    end else begin : g_l
      assign lefts[i] = ents[i-1];
    end
    if (i == N - 1) begin : g_rl
      assign rights[i] = edge_ent;
    end else begin : g_r
      assign rights[i] = ents[i+1];
    end
    segalloc_cell #(.IW(IW), .CW(CW), .INDEX(i)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cmd_k      (cmd_k),
      .count      (count),
      .scan_free  (op_q == segalloc_pkg::OP_FREE),
      .fit_mode   (fit_mode),
      .rid        (rid_q),
      .left       (lefts[i]),
      .right      (rights[i]),
      .tok_in     (toks[i]),
      .tok_in_idx (tok_idx[i]),
      .ent        (ents[i]),
      .tok_out    (toks[i+1]),
      .tok_out_idx(tok_idx[i+1])
    );
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign scan_done = (state == S_SCAN) && (scan_cnt == CW'(N));
  assign split     = toks[N].len > size_q;
  assign id_inc    = next_id + DW'(1);

  always_comb begin
    cmd.code     = segalloc_pkg::CMD_NONE;
    cmd.size     = size_q;
    cmd.id       = next_id;
    cmd.init_len = ({1'b0, arena_size} > {1'b0, ARENA_MAX}) ? ARENA_MAX
                                                              : LW'(arena_size);
    cmd_k        = k_q;
    case (state)
      S_INIT: cmd.code = segalloc_pkg::CMD_INIT;
      S_SCAN: begin
        cmd_k = tok_idx[N];
        if (scan_done && toks[N].found) begin
          if (op_q == segalloc_pkg::OP_FREE) begin
            cmd.code = segalloc_pkg::CMD_FREE;
          end else if (!split) begin
            cmd.code = segalloc_pkg::CMD_EXACT;
          end else if (count < CW'(N)) begin
            cmd.code = segalloc_pkg::CMD_SPLIT;
          end
        end
      end
      S_MERGE1: begin
        if (nfree_q) cmd.code = segalloc_pkg::CMD_MERGE;
      end
      S_MERGE2: begin
        cmd_k = k_q - IW'(1);
        if (pfree_q) cmd.code = segalloc_pkg::CMD_MERGE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode   <= segalloc_pkg::FIT_FIRST;
      arena_size <= 17'h10000;
    end else if (cfg_valid) begin
      case (cfg_index)
        segalloc_pkg::REG_FIT_MODE:   fit_mode   <= cfg_data[1:0];
        segalloc_pkg::REG_ARENA_SIZE: arena_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      next_id   <= DW'(1);
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      // in S_FIN the output register is reloaded below instead
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q       <= op;
            size_q     <= request_size;
            rid_q      <= release_id;
            scan_cnt   <= '0;
            res_status <= segalloc_pkg::ST_OK;
            res_id     <= '0;
            res_start  <= '0;
            state      <= S_FIN;
            case (op)
              segalloc_pkg::OP_ALLOC: begin
                if (count == '0) res_status <= segalloc_pkg::ST_NOINIT;
                else if (request_size == '0) res_status <= segalloc_pkg::ST_ZERO;
                else state <= S_SCAN;
              end
              segalloc_pkg::OP_FREE: begin
                if (count == '0) res_status <= segalloc_pkg::ST_NOINIT;
                else state <= S_SCAN;
              end
              segalloc_pkg::OP_INIT: state <= S_INIT;
              default: begin
              end
            endcase
          end
        end
        S_INIT: begin
          count <= CW'(1);
          state <= S_FIN;
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + CW'(1);
          if (scan_done) begin
            k_q     <= tok_idx[N];
            nfree_q <= toks[N].nfree;
            pfree_q <= toks[N].pfree;
            state   <= S_FIN;
            if (!toks[N].found) begin
              res_status <= (op_q == segalloc_pkg::OP_FREE) ? segalloc_pkg::ST_NOID
                                                             : segalloc_pkg::ST_NOFIT;
            end else if (op_q == segalloc_pkg::OP_FREE) begin
              state <= S_MERGE1;
            end else if (split && count >= CW'(N)) begin
              res_status <= segalloc_pkg::ST_FULL;
            end else begin
              if (split) count <= count + CW'(1);
              res_id    <= next_id;
              res_start <= toks[N].start;
              next_id   <= (id_inc == '0) ? DW'(1) : id_inc;
            end
          end
        end
        S_MERGE1: begin
          if (nfree_q) count <= count - CW'(1);
          state <= S_MERGE2;
        end
        S_MERGE2: begin
          if (pfree_q) count <= count - CW'(1);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            granted_id    <= res_id;
            granted_start <= res_start;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(N)) else $error("segment count above table size");
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_id != '0) else $error("owner id counter reached zero");
  a_split_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.code == segalloc_pkg::CMD_SPLIT |=> count == $past(count) + CW'(1))
    else $error("split did not add a table entry");
  a_scan_inited: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> count != '0) else $error("search on empty table");

endmodule
`default_nettype wire

>>> src/segalloc_cell.sv
// One table slot: holds a segment entry, passes the search token on and
// applies broadcast table commands. Depends on segalloc_pkg.
`default_nettype none
module segalloc_cell #(
  parameter int IW    = 6,
  parameter int CW    = 7,
  parameter int INDEX = 0
) (
  input  wire                          clk,
  input  segalloc_pkg::cmd_t           cmd,
  input  wire [IW-1:0]                 cmd_k,
  input  wire [CW-1:0]                 count,
  input  wire                          scan_free,
  input  wire [1:0]                    fit_mode,
  input  wire [segalloc_pkg::ID_W-1:0] rid,
  input  segalloc_pkg::entry_t         left,
  input  segalloc_pkg::entry_t         right,
  input  segalloc_pkg::tok_t           tok_in,
  input  wire [IW-1:0]                 tok_in_idx,
  output segalloc_pkg::entry_t         ent,
  output segalloc_pkg::tok_t           tok_out,
  output logic [IW-1:0]                tok_out_idx
);

  localparam logic [CW-1:0] ME = CW'(INDEX);

  logic                 active;
  logic                 elig;
  logic                 take;
  segalloc_pkg::tok_t   tok_next;
  logic [IW-1:0]        idx_next;
  logic [CW-1:0]        k_w;
  logic [CW-1:0]        k_p1;

  assign active = ME < count;
  assign k_w    = CW'(cmd_k);
  assign k_p1   = k_w + CW'(1);

  always_comb begin
    if (scan_free) begin
      elig = active && ent.used && (ent.owner == rid);
    end else begin
      elig = active && !ent.used && (ent.len >= cmd.size);
    end
    take = !tok_in.found;
    if (!scan_free && tok_in.found) begin
      if (fit_mode == segalloc_pkg::FIT_BEST) begin
        take = ent.len < tok_in.len;
      end else if (fit_mode == segalloc_pkg::FIT_WORST) begin
        take = ent.len > tok_in.len;
      end
    end
    tok_next       = tok_in;
    tok_next.fresh = 1'b0;
    idx_next       = tok_in_idx;
    if (tok_in.fresh) begin
      tok_next.nfree = active && !ent.used;
    end
    if (elig && take) begin
      tok_next.found = 1'b1;
      tok_next.fresh = 1'b1;
      tok_next.pfree = !left.used;
      tok_next.nfree = 1'b0;
      tok_next.len   = ent.len;
      tok_next.start = ent.start;
      idx_next       = IW'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    tok_out     <= tok_next;
    tok_out_idx <= idx_next;
    case (cmd.code)
      segalloc_pkg::CMD_INIT: begin
        if (ME == '0) begin
          ent.start <= '0;
          ent.len   <= cmd.init_len;
          ent.owner <= '0;
          ent.used  <= 1'b0;
        end
      end
      segalloc_pkg::CMD_EXACT: begin
        if (ME == k_w) begin
          ent.used  <= 1'b1;
          ent.owner <= cmd.id;
        end
      end
      segalloc_pkg::CMD_SPLIT: begin
        if (ME == k_w) begin
          ent.len   <= cmd.size;
          ent.used  <= 1'b1;
          ent.owner <= cmd.id;
        end else if (ME == k_p1) begin
          ent.start <= left.start + cmd.size[segalloc_pkg::ADDR_BITS-1:0];
          ent.len   <= left.len - cmd.size;
          ent.owner <= '0;
          ent.used  <= 1'b0;
        end else if (ME > k_p1) begin
          ent <= left;
        end
      end
      segalloc_pkg::CMD_FREE: begin
        if (ME == k_w) begin
          ent.used  <= 1'b0;
          ent.owner <= '0;
        end
      end
      segalloc_pkg::CMD_MERGE: begin
        if (ME == k_w) begin
          ent.len <= ent.len + right.len;
        end else if (ME > k_w) begin
          ent <= right;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for segment_allocator_fit_policy.
// Predicts the segment table in SystemVerilog and compares every result;
// depends on segalloc_pkg and the allocator RTL.
`timescale 1ns / 1ps
module tb_top;

  localparam int NSEG = 64;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [1:0] FIT_SPARE = 2'd3;

  typedef struct packed {
    logic [2:0]  st;
    logic [30:0] id;
    logic [15:0] start;
  } grant_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic [1:0]  op = '0;
  logic [16:0] request_size = '0;
  logic [30:0] release_id = '0;
  logic        out_ready = 0;
  logic        cfg_valid = 0;
  logic [0:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;
  wire         in_ready, out_valid, cfg_ready;
  wire [2:0]   status;
  wire [30:0]  granted_id;
  wire [15:0]  granted_start;

  segment_allocator_fit_policy dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // predictor state
  logic [15:0] tbl_start [NSEG+1];
  logic [16:0] tbl_len   [NSEG+1];
  logic [30:0] tbl_owner [NSEG+1];
  logic        tbl_used  [NSEG+1];
  int          tbl_count = 0;
  logic [30:0] id_next = 31'd1;
  logic [1:0]  mode = segalloc_pkg::FIT_FIRST;
  logic [16:0] arena = 17'd65536;

  grant_t      grants_due[$];
  logic [30:0] live_ids[$];
  int          fails = 0;
  bit          hold_off = 0;

  function automatic void drop_row(int k);
    for (int i = k; i + 1 < tbl_count; i++) begin
      tbl_start[i] = tbl_start[i+1];
      tbl_len[i]   = tbl_len[i+1];
      tbl_owner[i] = tbl_owner[i+1];
      tbl_used[i]  = tbl_used[i+1];
    end
    tbl_count--;
  endfunction

  function automatic grant_t predict_grant(logic [1:0] o, logic [16:0] sz, logic [30:0] rid);
    grant_t g;
    int pick;
    bit found;
    g = '0;
    pick = 0;
    found = 0;
    if (o == segalloc_pkg::OP_INIT) begin
      tbl_start[0] = '0;
      tbl_len[0]   = arena;
      tbl_owner[0] = '0;
      tbl_used[0]  = 0;
      tbl_count    = 1;
    end else if (o == segalloc_pkg::OP_ALLOC) begin
      if (tbl_count == 0) g.st = segalloc_pkg::ST_NOINIT;
      else if (sz == 0) g.st = segalloc_pkg::ST_ZERO;
      else begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_used[i] || tbl_len[i] < sz) continue;
          if (!found) begin
            pick = i;
            found = 1;
            if (mode != segalloc_pkg::FIT_BEST && mode != segalloc_pkg::FIT_WORST) break;
          end else if (mode == segalloc_pkg::FIT_BEST && tbl_len[i] < tbl_len[pick]) begin
            pick = i;
          end else if (mode == segalloc_pkg::FIT_WORST && tbl_len[i] > tbl_len[pick]) begin
            pick = i;
          end
        end
        if (!found) g.st = segalloc_pkg::ST_NOFIT;
        else if (tbl_len[pick] > sz && tbl_count >= NSEG) g.st = segalloc_pkg::ST_FULL;
        else begin
          if (tbl_len[pick] > sz) begin
            for (int i = tbl_count; i > pick + 1; i--) begin
              tbl_start[i] = tbl_start[i-1];
              tbl_len[i]   = tbl_len[i-1];
              tbl_owner[i] = tbl_owner[i-1];
              tbl_used[i]  = tbl_used[i-1];
            end
            tbl_start[pick+1] = tbl_start[pick] + sz[15:0];
            tbl_len[pick+1]   = tbl_len[pick] - sz;
            tbl_owner[pick+1] = '0;
            tbl_used[pick+1]  = 0;
            tbl_len[pick]     = sz;
            tbl_count++;
          end
          tbl_used[pick]  = 1;
          tbl_owner[pick] = id_next;
          g.id    = id_next;
          g.start = tbl_start[pick];
          live_ids.push_back(id_next);
          id_next = id_next + 31'd1;
          if (id_next == 0) id_next = 31'd1;
        end
      end
    end else if (o == segalloc_pkg::OP_FREE) begin
      if (tbl_count == 0) g.st = segalloc_pkg::ST_NOINIT;
      else begin
        g.st = segalloc_pkg::ST_NOID;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_used[i] && tbl_owner[i] == rid) begin
            int j;
            tbl_used[i]  = 0;
            tbl_owner[i] = '0;
            j = 0;
            while (j + 1 < tbl_count) begin
              if (!tbl_used[j] && !tbl_used[j+1]) begin
                tbl_len[j] = tbl_len[j] + tbl_len[j+1];
                drop_row(j + 1);
              end else j++;
            end
            g.st = segalloc_pkg::ST_OK;
            break;
          end
        end
      end
    end
    return g;
  endfunction

  // valid stays up across a zero gap; it drops before any idle cycles
  task automatic send_op(logic [1:0] o, logic [16:0] sz, logic [30:0] rid);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    op <= o;
    request_size <= sz;
    release_id <= rid;
    do @(posedge clk); while (!in_ready);
    grants_due.push_back(predict_grant(o, sz, rid));
  endtask

  task automatic write_reg(logic [0:0] idx, logic [16:0] val);
    wait_idle();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == segalloc_pkg::REG_FIT_MODE) mode = val[1:0];
    else arena = (val > 17'd65536) ? 17'd65536 : val;
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (NSEG + 10) @(posedge clk);
  endtask

  task automatic free_some();
    int k;
    if (live_ids.size() == 0) return;
    k = $urandom_range(0, live_ids.size() - 1);
    send_op(segalloc_pkg::OP_FREE, '0, live_ids[k]);
    live_ids.delete(k);
  endtask

  // receiver: a drawn wait before each transaction, plus a long hold-off
  initial begin
    int w;
    w = $urandom_range(0, 7);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) w = $urandom_range(0, 7);
      if (hold_off) out_ready <= 0;
      else if (w != 0) begin
        out_ready <= 0;
        w--;
      end else out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      grant_t g;
      if (grants_due.size() == 0) begin
        $error("result with no transaction pending");
        fails++;
      end else begin
        g = grants_due.pop_front();
        if (status !== g.st) begin
          $error("status exp %0d got %0d", g.st, status);
          fails++;
        end
        if (granted_id !== g.id) begin
          $error("granted_id exp %0d got %0d", g.id, granted_id);
          fails++;
        end
        if (granted_start !== g.start) begin
          $error("granted_start exp %0d got %0d", g.start, granted_start);
          fails++;
        end
      end
    end
  end

  task automatic test_directed();
    send_op(segalloc_pkg::OP_ALLOC, 17'd5, '0);          // before init
    send_op(segalloc_pkg::OP_FREE, '0, 31'd1);
    send_op(OP_SPARE, 17'h1FFFF, 31'h7FFFFFFF);
    send_op(segalloc_pkg::OP_INIT, '0, '0);
    send_op(segalloc_pkg::OP_ALLOC, '0, '0);             // zero size
    send_op(segalloc_pkg::OP_ALLOC, 17'd65536, '0);      // whole arena, exact fit
    send_op(segalloc_pkg::OP_ALLOC, 17'd1, '0);
    send_op(segalloc_pkg::OP_FREE, '0, 31'd0);
    send_op(segalloc_pkg::OP_FREE, '0, 31'h7FFFFFFF);
    send_op(segalloc_pkg::OP_FREE, '0, 31'd1);
    send_op(segalloc_pkg::OP_FREE, '0, 31'd1);           // already released
    send_op(segalloc_pkg::OP_ALLOC, 17'h1FFFF, '0);
    send_op(segalloc_pkg::OP_ALLOC, 17'd100, '0);
    send_op(segalloc_pkg::OP_ALLOC, 17'd200, '0);
    send_op(segalloc_pkg::OP_ALLOC, 17'd100, '0);
    send_op(segalloc_pkg::OP_FREE, '0, 31'd2);
    send_op(segalloc_pkg::OP_FREE, '0, 31'd4);
    send_op(segalloc_pkg::OP_FREE, '0, 31'd3);           // merges both sides
  endtask

  task automatic test_small_arenas();
    write_reg(segalloc_pkg::REG_ARENA_SIZE, 17'd0);
    send_op(segalloc_pkg::OP_INIT, '0, '0);
    send_op(segalloc_pkg::OP_ALLOC, 17'd1, '0);
    write_reg(segalloc_pkg::REG_ARENA_SIZE, 17'd1);
    send_op(segalloc_pkg::OP_INIT, '0, '0);
    send_op(segalloc_pkg::OP_ALLOC, 17'd1, '0);
    send_op(segalloc_pkg::OP_ALLOC, 17'd1, '0);
  endtask

  // fills the table with one-unit grants until it reports full
  task automatic test_table_full();
    write_reg(segalloc_pkg::REG_FIT_MODE, 17'(segalloc_pkg::FIT_FIRST));
    write_reg(segalloc_pkg::REG_ARENA_SIZE, 17'd1000);
    send_op(segalloc_pkg::OP_INIT, '0, '0);
    live_ids.delete();
    repeat (NSEG + 2) send_op(segalloc_pkg::OP_ALLOC, 17'd1, '0);
    send_op(segalloc_pkg::OP_ALLOC, 17'(1000 - NSEG + 1), '0); // exact fit of the tail
    repeat (8) free_some();
  endtask

  task automatic test_random(int n_items, logic [1:0] fm, logic [16:0] sz_arena);
    write_reg(segalloc_pkg::REG_FIT_MODE, 17'(fm));
    write_reg(segalloc_pkg::REG_ARENA_SIZE, sz_arena);
    send_op(segalloc_pkg::OP_INIT, '0, '0);
    live_ids.delete();
    for (int i = 0; i < n_items; i++) begin
      int r;
      logic [16:0] sz;
      r = $urandom_range(0, 99);
      sz = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(1, 300));
      if (r < 50) send_op(segalloc_pkg::OP_ALLOC, sz, 31'($urandom));
      else if (r < 88) free_some();
      else if (r < 94) send_op(segalloc_pkg::OP_FREE, sz, 31'($urandom));
      else if (r < 96) send_op(OP_SPARE, sz, 31'($urandom));
      else if (r < 97) begin
        send_op(segalloc_pkg::OP_INIT, sz, 31'($urandom));
        live_ids.delete();
      end else send_op(segalloc_pkg::OP_ALLOC, 17'($urandom_range(0, 2)), 31'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    fork
      begin
        for (int i = 0; i < 6; i++) send_op(segalloc_pkg::OP_ALLOC, 17'd3, '0);
        in_valid <= 0;
      end
      begin
        int c;
        c = 0;
        while (c < 400) begin
          @(posedge clk);
          c++;
        end
        hold_off = 0;
      end
    join
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_small_arenas();
    test_table_full();
    test_backpressure();
    test_random(350, segalloc_pkg::FIT_FIRST, 17'd65536);
    test_random(350, segalloc_pkg::FIT_BEST, 17'd4000);
    test_random(350, segalloc_pkg::FIT_WORST, 17'h1FFFF);
    test_random(300, FIT_SPARE, 17'd2500);
    wait_idle();
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
